// ===== rtl/kcp_pkg.sv =====
// shared types, codes and defaults for the keyed slot cache
package kcp_pkg;

  localparam int SlotsDefault    = 32;
  localparam int KeyBytesDefault = 8;

  localparam logic [2:0] RES_HIT   = 3'd0;
  localparam logic [2:0] RES_ADDED = 3'd1;
  localparam logic [2:0] RES_BUSY  = 3'd2;
  localparam logic [2:0] RES_FULL  = 3'd3;
  localparam logic [2:0] RES_DONE  = 3'd4;
  localparam logic [2:0] RES_ERROR = 3'd5;

  localparam logic [1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [1:0] MODE_REMOVE  = 2'd1;
  localparam logic [1:0] MODE_FILL    = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_PENDING = 2'd1,
    ST_VALID   = 2'd2
  } slot_st_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ERR,
    CMD_ORD_RD_POS,
    CMD_ORD_RD_PREV,
    CMD_ORD_RD_NEXT,
    CMD_CUR_FROM_ORD,
    CMD_NEXT,
    CMD_PREV,
    CMD_BUSY,
    CMD_HIT,
    CMD_HIT_RES,
    CMD_ORD_WR_DN,
    CMD_ORD_WR_UP,
    CMD_ORD_WR_HEAD,
    CMD_POP,
    CMD_FULL,
    CMD_SET_TAIL,
    CMD_EVICT,
    CMD_DEC_UCOUNT,
    CMD_ADD,
    CMD_FREE,
    CMD_FILL,
    CMD_REL,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic [1:0] mode;
    logic       slot_oor;
    logic       slot_pending;
    logic       slot_releasable;
    logic       ucount_zero;
    logic       pos_zero;
    logic       pos_one;
    logic       pos_last;
    logic       key_match;
    logic       cur_valid;
    logic       free_avail;
    logic       victim_ok;
    logic       ord_match;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/kcp_ram.sv =====
// generic single write, single read ram with registered read data
module kcp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/kcp_dp.sv =====
// datapath: slot tables, use list, free fifo and result registers
module kcp_dp #(
  parameter int Slots    = kcp_pkg::SlotsDefault,
  parameter int KeyBytes = kcp_pkg::KeyBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kcp_pkg::cmd_e     cmd_i,
  output kcp_pkg::dp_stat_t stat_o,
  input  logic [1:0]        mode_i,
  input  logic [63:0]       key_i,
  input  logic [4:0]        slot_i,
  input  logic [31:0]       object_id_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [4:0]        slot_out_o,
  output logic [31:0]       object_out_o,
  output logic              evicted_o,
  output logic [31:0]       evicted_object_o
);
  import kcp_pkg::*;

  localparam int SW = $clog2(Slots);
  localparam int CW = $clog2(Slots + 1);
  localparam int KW = 8 * KeyBytes;

  logic [1:0]    mode_q;
  logic [KW-1:0] key_q;
  logic [4:0]    slot_q;
  logic [31:0]   obj_q;
  logic [SW-1:0] cur_q;
  logic [SW-1:0] pos_q;
  logic          ev_q;
  logic [31:0]   evobj_q;
  logic [2:0]    res_st_q;
  logic [4:0]    res_slot_q;
  logic [31:0]   res_obj_q;
  logic          res_ev_q;
  logic [31:0]   res_evobj_q;
  logic          out_valid_q;
  logic [2:0]    out_st_q;
  logic [4:0]    out_slot_q;
  logic [31:0]   out_obj_q;
  logic          out_ev_q;
  logic [31:0]   out_evobj_q;

  slot_st_e      st_q [Slots];
  logic [15:0]   rc_q [Slots];
  logic [SW-1:0] ff_q [Slots];
  logic [SW-1:0] fhead_q;
  logic [CW-1:0] fcount_q;
  logic [CW-1:0] ucount_q;

  logic [SW-1:0] slot_ix;
  logic [SW-1:0] ord_rdata;
  logic [KW-1:0] key_rdata;
  logic [31:0]   obj_rdata;
  logic [SW-1:0] ord_raddr;
  logic          ord_we;
  logic [SW-1:0] ord_waddr;
  logic [SW-1:0] ord_wdata;
  logic          obj_we;
  logic [SW-1:0] obj_waddr;
  logic [31:0]   obj_wdata;
  logic [SW-1:0] obj_raddr;
  logic [CW:0]   tail_sum;
  logic [SW-1:0] ftail;
  logic          out_free;

  assign slot_ix  = SW'(slot_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign tail_sum = {1'b0, CW'(fhead_q)} + {1'b0, fcount_q};
  assign ftail    = (tail_sum >= (CW + 1)'(Slots)) ? SW'(tail_sum - (CW + 1)'(Slots))
                                                     : SW'(tail_sum);

  always_comb begin
    stat_o.mode            = mode_q;
    stat_o.slot_oor        = {4'd0, slot_q} >= 9'(Slots);
    stat_o.slot_pending    = st_q[slot_ix] == ST_PENDING;
    stat_o.slot_releasable = (st_q[slot_ix] == ST_VALID) && (rc_q[slot_ix] > 16'd1);
    stat_o.ucount_zero     = ucount_q == '0;
    stat_o.pos_zero        = pos_q == '0;
    stat_o.pos_one         = pos_q == SW'(1);
    stat_o.pos_last        = (CW'(pos_q) + CW'(1)) == ucount_q;
    stat_o.key_match       = key_rdata == key_q;
    stat_o.cur_valid       = st_q[cur_q] == ST_VALID;
    stat_o.free_avail      = fcount_q != '0;
    stat_o.victim_ok       = (st_q[cur_q] == ST_VALID) && (rc_q[cur_q] <= 16'd1);
    stat_o.ord_match       = ord_rdata == slot_ix;
    stat_o.out_free        = out_free;
  end

  always_comb begin
    ord_raddr = pos_q;
    ord_we    = 1'b0;
    ord_waddr = pos_q;
    ord_wdata = ord_rdata;
    obj_we    = 1'b0;
    obj_waddr = cur_q;
    obj_wdata = '0;
    obj_raddr = ord_rdata;
    unique case (cmd_i)
      CMD_ORD_RD_PREV: ord_raddr = pos_q - SW'(1);
      CMD_ORD_RD_NEXT: ord_raddr = pos_q + SW'(1);
      CMD_HIT:         obj_raddr = cur_q;
      CMD_ORD_WR_DN,
      CMD_ORD_WR_UP:   ord_we = 1'b1;
      CMD_ORD_WR_HEAD: begin
        ord_we    = 1'b1;
        ord_waddr = '0;
        ord_wdata = cur_q;
      end
      CMD_ADD: begin
        ord_we    = ucount_q < CW'(Slots);
        ord_waddr = SW'(ucount_q);
        ord_wdata = cur_q;
        obj_we    = 1'b1;
      end
      CMD_FILL: begin
        obj_we    = 1'b1;
        obj_waddr = slot_ix;
        obj_wdata = obj_q;
      end
      default: ;
    endcase
  end

  kcp_ram #(.Width(SW), .Depth(Slots)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  kcp_ram #(.Width(KW), .Depth(Slots)) u_keys (
    .clk_i, .we_i(cmd_i == CMD_ADD), .waddr_i(cur_q), .wdata_i(key_q),
    .raddr_i(ord_rdata), .rdata_o(key_rdata)
  );

  kcp_ram #(.Width(32), .Depth(Slots)) u_objs (
    .clk_i, .we_i(obj_we), .waddr_i(obj_waddr), .wdata_i(obj_wdata),
    .raddr_i(obj_raddr), .rdata_o(obj_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        st_q[i] <= ST_FREE;
        rc_q[i] <= '0;
        ff_q[i] <= SW'(i);
      end
      fhead_q     <= '0;
      fcount_q    <= CW'(Slots);
      ucount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i)
        CMD_HIT: begin
          if (rc_q[cur_q] != 16'hFFFF) begin
            rc_q[cur_q] <= rc_q[cur_q] + 16'd1;
          end
        end
        CMD_POP: begin
          fhead_q  <= (fhead_q == SW'(Slots - 1)) ? '0 : fhead_q + SW'(1);
          fcount_q <= fcount_q - CW'(1);
        end
        CMD_EVICT:      rc_q[cur_q] <= '0;
        CMD_DEC_UCOUNT: ucount_q <= ucount_q - CW'(1);
        CMD_ADD: begin
          st_q[cur_q] <= ST_PENDING;
          if (ucount_q < CW'(Slots)) begin
            ucount_q <= ucount_q + CW'(1);
          end
        end
        CMD_FREE: begin
          st_q[slot_ix] <= ST_FREE;
          rc_q[slot_ix] <= '0;
          if (fcount_q < CW'(Slots)) begin
            ff_q[ftail] <= slot_ix;
            fcount_q    <= fcount_q + CW'(1);
          end
        end
        CMD_FILL: begin
          st_q[slot_ix] <= ST_VALID;
          rc_q[slot_ix] <= 16'd2;
        end
        CMD_REL:  rc_q[slot_ix] <= rc_q[slot_ix] - 16'd1;
        CMD_EMIT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        mode_q  <= mode_i;
        key_q   <= key_i[KW-1:0];
        slot_q  <= slot_i;
        obj_q   <= object_id_i;
        pos_q   <= '0;
        ev_q    <= 1'b0;
        evobj_q <= '0;
      end
      CMD_ERR: begin
        res_st_q   <= RES_ERROR;
        res_slot_q <= slot_q;
        res_obj_q  <= '0;
        res_ev_q   <= 1'b0;
        res_evobj_q <= '0;
      end
      CMD_CUR_FROM_ORD: cur_q <= ord_rdata;
      CMD_NEXT:         pos_q <= pos_q + SW'(1);
      CMD_PREV:         pos_q <= pos_q - SW'(1);
      CMD_BUSY: begin
        res_st_q    <= RES_BUSY;
        res_slot_q  <= 5'(cur_q);
        res_obj_q   <= '0;
        res_ev_q    <= 1'b0;
        res_evobj_q <= '0;
      end
      CMD_HIT_RES: begin
        res_st_q    <= RES_HIT;
        res_slot_q  <= 5'(cur_q);
        res_obj_q   <= obj_rdata;
        res_ev_q    <= 1'b0;
        res_evobj_q <= '0;
      end
      CMD_ORD_WR_DN: pos_q <= pos_q - SW'(1);
      CMD_ORD_WR_UP: pos_q <= pos_q + SW'(1);
      CMD_POP:       cur_q <= ff_q[fhead_q];
      CMD_FULL: begin
        res_st_q    <= RES_FULL;
        res_slot_q  <= '0;
        res_obj_q   <= '0;
        res_ev_q    <= 1'b0;
        res_evobj_q <= '0;
      end
      CMD_SET_TAIL: pos_q <= SW'(ucount_q - CW'(1));
      CMD_EVICT: begin
        ev_q    <= 1'b1;
        evobj_q <= obj_rdata;
      end
      CMD_ADD: begin
        res_st_q    <= RES_ADDED;
        res_slot_q  <= 5'(cur_q);
        res_obj_q   <= '0;
        res_ev_q    <= ev_q;
        res_evobj_q <= evobj_q;
      end
      CMD_FREE,
      CMD_REL: begin
        res_st_q    <= RES_DONE;
        res_slot_q  <= slot_q;
        res_obj_q   <= '0;
        res_ev_q    <= 1'b0;
        res_evobj_q <= '0;
      end
      CMD_FILL: begin
        res_st_q    <= RES_DONE;
        res_slot_q  <= slot_q;
        res_obj_q   <= obj_q;
        res_ev_q    <= 1'b0;
        res_evobj_q <= '0;
      end
      CMD_EMIT: begin
        out_st_q    <= res_st_q;
        out_slot_q  <= res_slot_q;
        out_obj_q   <= res_obj_q;
        out_ev_q    <= res_ev_q;
        out_evobj_q <= res_evobj_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign slot_out_o       = out_slot_q;
  assign object_out_o     = out_obj_q;
  assign evicted_o        = out_ev_q;
  assign evicted_object_o = out_evobj_q;

`ifndef SYNTHESIS
  a_slots_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_LOAD |-> (CW + 1)'(ucount_q) + (CW + 1)'(fcount_q) == (CW + 1)'(Slots))
    else $error("list and free fifo do not account for every slot");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_POP |-> fcount_q != '0)
    else $error("pop from empty free fifo");
  a_add_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_ADD |-> ucount_q < CW'(Slots))
    else $error("append to full use list");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_EMIT |-> out_free)
    else $error("result overwrites a beat not yet taken");
`endif

endmodule

// ===== rtl/kcp_ctrl.sv =====
// controller: sequences lookup, eviction, list shifts and result hand-off
module kcp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kcp_pkg::dp_stat_t stat_i,
  output kcp_pkg::cmd_e     cmd_o
);
  import kcp_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE     = 23'h000001,
    S_DISPATCH = 23'h000002,
    S_SC_ORD   = 23'h000004,
    S_SC_KEY   = 23'h000008,
    S_SC_CMP   = 23'h000010,
    S_HIT_OBJ  = 23'h000020,
    S_MTF_RD   = 23'h000040,
    S_MTF_WR   = 23'h000080,
    S_MTF_HEAD = 23'h000100,
    S_MISS     = 23'h000200,
    S_EV_ORD   = 23'h000400,
    S_EV_CHK   = 23'h000800,
    S_EV_TEST  = 23'h001000,
    S_RS_CHK   = 23'h002000,
    S_RS_RD    = 23'h004000,
    S_RS_WR    = 23'h008000,
    S_ADD      = 23'h010000,
    S_RM_ORD   = 23'h020000,
    S_RM_CMP   = 23'h040000,
    S_RM_FREE  = 23'h080000,
    S_FILL     = 23'h100000,
    S_REL      = 23'h200000,
    S_FIN      = 23'h400000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.mode == MODE_LOOKUP) begin
          state_d = stat_i.ucount_zero ? S_MISS : S_SC_ORD;
        end else if (stat_i.slot_oor) begin
          cmd_o   = CMD_ERR;
          state_d = S_FIN;
        end else if (stat_i.mode == MODE_RELEASE) begin
          if (stat_i.slot_releasable) begin
            state_d = S_REL;
          end else begin
            cmd_o   = CMD_ERR;
            state_d = S_FIN;
          end
        end else if (!stat_i.slot_pending) begin
          cmd_o   = CMD_ERR;
          state_d = S_FIN;
        end else begin
          state_d = (stat_i.mode == MODE_FILL) ? S_FILL : S_RM_ORD;
        end
      end
      S_SC_ORD: begin
        cmd_o   = CMD_ORD_RD_POS;
        state_d = S_SC_KEY;
      end
      S_SC_KEY: begin
        cmd_o   = CMD_CUR_FROM_ORD;
        state_d = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (stat_i.key_match && !stat_i.cur_valid) begin
          cmd_o   = CMD_BUSY;
          state_d = S_FIN;
        end else if (stat_i.key_match) begin
          cmd_o   = CMD_HIT;
          state_d = S_HIT_OBJ;
        end else begin
          cmd_o   = CMD_NEXT;
          state_d = stat_i.pos_last ? S_MISS : S_SC_ORD;
        end
      end
      S_HIT_OBJ: begin
        cmd_o   = CMD_HIT_RES;
        state_d = stat_i.pos_zero ? S_MTF_HEAD : S_MTF_RD;
      end
      S_MTF_RD: begin
        cmd_o   = CMD_ORD_RD_PREV;
        state_d = S_MTF_WR;
      end
      S_MTF_WR: begin
        cmd_o   = CMD_ORD_WR_DN;
        state_d = stat_i.pos_one ? S_MTF_HEAD : S_MTF_RD;
      end
      S_MTF_HEAD: begin
        cmd_o   = CMD_ORD_WR_HEAD;
        state_d = S_FIN;
      end
      S_MISS: begin
        if (stat_i.free_avail) begin
          cmd_o   = CMD_POP;
          state_d = S_ADD;
        end else if (stat_i.ucount_zero) begin
          cmd_o   = CMD_FULL;
          state_d = S_FIN;
        end else begin
          cmd_o   = CMD_SET_TAIL;
          state_d = S_EV_ORD;
        end
      end
      S_EV_ORD: begin
        cmd_o   = CMD_ORD_RD_POS;
        state_d = S_EV_CHK;
      end
      S_EV_CHK: begin
        cmd_o   = CMD_CUR_FROM_ORD;
        state_d = S_EV_TEST;
      end
      S_EV_TEST: begin
        if (stat_i.victim_ok) begin
          cmd_o   = CMD_EVICT;
          state_d = S_RS_CHK;
        end else if (stat_i.pos_zero) begin
          cmd_o   = CMD_FULL;
          state_d = S_FIN;
        end else begin
          cmd_o   = CMD_PREV;
          state_d = S_EV_ORD;
        end
      end
      S_RS_CHK: begin
        if (stat_i.pos_last) begin
          cmd_o   = CMD_DEC_UCOUNT;
          state_d = (stat_i.mode == MODE_LOOKUP) ? S_ADD : S_RM_FREE;
        end else begin
          state_d = S_RS_RD;
        end
      end
      S_RS_RD: begin
        cmd_o   = CMD_ORD_RD_NEXT;
        state_d = S_RS_WR;
      end
      S_RS_WR: begin
        cmd_o   = CMD_ORD_WR_UP;
        state_d = S_RS_CHK;
      end
      S_ADD: begin
        cmd_o   = CMD_ADD;
        state_d = S_FIN;
      end
      S_RM_ORD: begin
        cmd_o   = CMD_ORD_RD_POS;
        state_d = S_RM_CMP;
      end
      S_RM_CMP: begin
        if (stat_i.ord_match) begin
          state_d = S_RS_CHK;
        end else if (stat_i.pos_last) begin
          state_d = S_RM_FREE;
        end else begin
          cmd_o   = CMD_NEXT;
          state_d = S_RM_ORD;
        end
      end
      S_RM_FREE: begin
        cmd_o   = CMD_FREE;
        state_d = S_FIN;
      end
      S_FILL: begin
        cmd_o   = CMD_FILL;
        state_d = S_FIN;
      end
      S_REL: begin
        cmd_o   = CMD_REL;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o   = CMD_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o == CMD_LOAD |=> state_q == S_DISPATCH)
    else $error("item load outside idle");
  a_emit_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o == CMD_EMIT |=> !in_stall_o)
    else $error("controller stuck after result");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("stall raised without an accepted beat");
`endif

endmodule

// ===== rtl/keyed_cache_with_pinned_eviction.sv =====
// keyed slot cache with move-to-front lookup and pinned-entry eviction
// usage: one request beat on the in channel (mode, key, slot, object_id),
// one result beat on the out channel for every request, in order.
// a beat moves when valid is high and stall is low on that channel.
// in_stall_o stays high from the accepted beat until its result sits in the
// output register; the next request is taken while that result still waits.
// steps: fill and release update the slot, errors go straight to the result;
// a lookup scans the list from the head and moves a hit entry to the front;
// a miss scans the whole list, then pops the free fifo or walks from the
// tail to an unpinned victim and closes the gap entry by entry; remove
// searches the list for the slot, then closes the gap the same way and frees it.
// when out_stall_i holds a result, the block finishes the current request and
// waits before loading its result, then accepts again.
// reset: all slots free, free fifo holds slots in order, no output beat;
// no clearing pass is needed.
module keyed_cache_with_pinned_eviction #(
  parameter int Slots    = kcp_pkg::SlotsDefault,
  parameter int KeyBytes = kcp_pkg::KeyBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] key_i,
  input  logic [4:0]  slot_i,
  input  logic [31:0] object_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [4:0]  slot_out_o,
  output logic [31:0] object_out_o,
  output logic        evicted_o,
  output logic [31:0] evicted_object_o
);
  import kcp_pkg::*;

  cmd_e     cmd;
  dp_stat_t stat;

  kcp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .stat_i(stat), .cmd_o(cmd)
  );

  kcp_dp #(.Slots(Slots), .KeyBytes(KeyBytes)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .mode_i, .key_i, .slot_i, .object_id_i,
    .out_valid_o, .out_stall_i, .status_o, .slot_out_o, .object_out_o,
    .evicted_o, .evicted_object_o
  );

endmodule
